// ===== sv/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

	localparam int unsigned LUM_FRAC_BITS_DEF = 16;

	// linearization table construction, worked in Q0.30
	localparam int unsigned HP_BITS      = 30;
	localparam logic [63:0] LIN_LOW_DEN  = 64'd32946;
	localparam logic [63:0] LIN_LOW_HALF = 64'd16473;
	localparam logic [63:0] LIN_DEN      = 64'd269025;
	localparam logic [63:0] LIN_OFFSET   = 64'd14025;
	localparam int unsigned LIN_KNEE     = 10;

	// luminance weights, scaled by LUMA_SCALE
	localparam int unsigned W_RED      = 2126;
	localparam int unsigned W_GREEN    = 7152;
	localparam int unsigned W_BLUE     = 722;
	localparam int unsigned LUMA_SCALE = 10000;
	localparam int unsigned LUMA_BIAS  = 5000;

	// a = 20 * l + 1.0 stands for 20 * (l + 0.05)
	localparam int unsigned A_SCALE      = 20;
	localparam int unsigned CONTRAST_MAX = 21;

	localparam int unsigned       THR_W     = 13;
	localparam int unsigned       THR_FRAC  = 8;
	localparam logic [THR_W-1:0]  THR_RESET = 13'd768;

	localparam logic [31:0] BLACK_ARGB = 32'hFF00_0000;
	localparam logic [31:0] WHITE_ARGB = 32'hFFFF_FFFF;

	localparam int unsigned QUEUE_DEPTH = 8;

	typedef struct packed {
		logic [31:0] background_color;
		logic [31:0] text_color;
	} in_item_t;

	typedef struct packed {
		logic [31:0] text_color_out;
		logic        replaced;
	} out_item_t;

	function automatic logic [63:0] pow5_hp(logic [63:0] z);
		logic [63:0] p;
		p = z;
		for (int i = 0; i < 4; i++) begin
			p = (p * z) >> HP_BITS;
		end
		return p;
	endfunction

	// srgb to linear, evaluated at elaboration only
	function automatic logic [31:0] lin_entry(int unsigned v, int unsigned frac);
		logic [63:0] h;
		logic [63:0] n;
		logic [63:0] xq;
		logic [63:0] x2;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		h  = 64'd0;
		lo = 64'd0;
		hi = 64'd1 << HP_BITS;
		if (v <= LIN_KNEE) begin
			h = (((64'(v) * 64'd10) << HP_BITS) + LIN_LOW_HALF) / LIN_LOW_DEN;
		end else begin
			n  = 64'd1000 * 64'(v) + LIN_OFFSET;
			xq = ((n << HP_BITS) + (LIN_DEN >> 1)) / LIN_DEN;
			x2 = (xq * xq + (64'd1 << (HP_BITS - 1))) >> HP_BITS;
			for (int i = 0; i < 32; i++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (pow5_hp(mid) <= x2) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
			h = (x2 * lo + (64'd1 << (HP_BITS - 1))) >> HP_BITS;
		end
		return 32'((h + (64'd1 << (HP_BITS - frac - 1))) >> (HP_BITS - frac));
	endfunction

endpackage

// ===== sv/text_contrast_corrector.sv =====
`timescale 1ns / 1ps
// text contrast corrector
// in channel: in_valid / in_stall carry a background and a text color (argb)
// out channel: out_valid / out_stall carry the text color to use and a
// replaced flag; a low-contrast text color becomes opaque black or white
// config: cfg_we writes cfg_data into the minimum contrast register (q5.8),
// which reads 3.0 after reset; write it only while no item is in flight
// an accepted item passes the pipeline stages below and then the result queue
// throughput: one item per cycle while in_stall is low; six pipeline stages
// (table lookup, weighted sum, two reciprocal-multiply stages, correction,
// contrast products) feed an 8-entry result queue
// in_stall comes from a credit counter of accepted but undelivered items, so
// it depends only on registers and does not follow out_stall in the same cycle;
// in_stall rises once 8 items are accepted and not yet taken
// reset (arst_n low) empties the pipe and the queue and restores the register

module text_contrast_corrector #(
	parameter int unsigned LUM_FRAC_BITS = tcc_pkg::LUM_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tcc_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tcc_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic [tcc_pkg::THR_W-1:0] cfg_data
);

	localparam int unsigned AW = LUM_FRAC_BITS + 5;

	logic [tcc_pkg::THR_W-1:0] thr_q;
	logic                      in_acc;
	logic                      vld_s1;
	logic                      vld_s2;
	logic                      vld_s3;
	logic                      vld_s4;
	logic                      vld_s5;
	logic [31:0]               tx_s1;
	logic [31:0]               tx_s2;
	logic [31:0]               tx_s3;
	logic [31:0]               tx_s4;
	logic [31:0]               tx_s5;
	logic [AW-1:0]             abg_s5;
	logic [AW-1:0]             atx_s5;
	logic                      res_valid;
	tcc_pkg::out_item_t        res;

	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tcc_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tx_s1 <= in_data.text_color;
		tx_s2 <= tx_s1;
		tx_s3 <= tx_s2;
		tx_s4 <= tx_s3;
		tx_s5 <= tx_s4;
	end

	tcc_luma #(
		.LUM_FRAC_BITS(LUM_FRAC_BITS)
	) u_luma_bg (
		.clk  (clk),
		.color(in_data.background_color),
		.a_s5 (abg_s5)
	);

	tcc_luma #(
		.LUM_FRAC_BITS(LUM_FRAC_BITS)
	) u_luma_tx (
		.clk  (clk),
		.color(in_data.text_color),
		.a_s5 (atx_s5)
	);

	tcc_compare #(
		.LUM_FRAC_BITS(LUM_FRAC_BITS)
	) u_compare (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s5  (vld_s5),
		.a_bg      (abg_s5),
		.a_tx      (atx_s5),
		.text_color(tx_s5),
		.thr       (thr_q),
		.res_valid (res_valid),
		.res       (res)
	);

	tcc_out_queue #(
		.DEPTH(tcc_pkg::QUEUE_DEPTH)
	) u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.in_stall (in_stall),
		.wr_en    (res_valid),
		.wr_data  (res),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== sv/tcc_luma.sv =====
`timescale 1ns / 1ps

module tcc_luma #(
	parameter int unsigned LUM_FRAC_BITS = tcc_pkg::LUM_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic [31:0]                color,
	output logic [LUM_FRAC_BITS+4:0]   a_s5
);

	localparam int unsigned F  = LUM_FRAC_BITS;
	localparam int unsigned EW = F + 1;
	localparam int unsigned SW = F + 14;
	localparam int unsigned HW = SW / 2;
	localparam int unsigned QW = F + 1;
	localparam int unsigned AW = F + 5;
	localparam int unsigned LW = HW + QW;
	localparam int unsigned UW = SW - HW + QW;
	localparam int unsigned FW = SW + QW;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SW) / 64'(tcc_pkg::LUMA_SCALE);
	localparam logic [QW-1:0] RECIP = RECIP_FULL[QW-1:0];

	logic [EW-1:0] rom_w [256];

	for (genvar gv = 0; gv < 256; gv++) begin : g_rom
		localparam logic [31:0] ENTRY = tcc_pkg::lin_entry(gv, F);
		assign rom_w[gv] = ENTRY[EW-1:0];
	end

	logic [EW-1:0] lin_r_s1;
	logic [EW-1:0] lin_g_s1;
	logic [EW-1:0] lin_b_s1;
	logic [SW-1:0] sum_s2;
	logic [SW-1:0] sum_s3;
	logic [SW-1:0] sum_s4;
	logic [LW-1:0] pp_lo_s3;
	logic [UW-1:0] pp_hi_s3;
	logic [QW-1:0] qest_s4;
	logic [FW-1:0] full_prod;
	logic [SW-1:0] rem;
	logic [AW-1:0] a_est;

	always_ff @(posedge clk) begin
		lin_r_s1 <= rom_w[color[23:16]];
		lin_g_s1 <= rom_w[color[15:8]];
		lin_b_s1 <= rom_w[color[7:0]];
	end

	always_ff @(posedge clk) begin
		sum_s2 <= SW'(lin_r_s1) * SW'(tcc_pkg::W_RED)
			+ SW'(lin_g_s1) * SW'(tcc_pkg::W_GREEN)
			+ SW'(lin_b_s1) * SW'(tcc_pkg::W_BLUE)
			+ SW'(tcc_pkg::LUMA_BIAS);
	end

	// divide by 10000: reciprocal split into two partial products
	always_ff @(posedge clk) begin
		pp_lo_s3 <= LW'(sum_s2[HW-1:0]) * LW'(RECIP);
		pp_hi_s3 <= UW'(sum_s2[SW-1:HW]) * UW'(RECIP);
		sum_s3   <= sum_s2;
	end

	assign full_prod = (FW'(pp_hi_s3) << HW) + FW'(pp_lo_s3);

	always_ff @(posedge clk) begin
		qest_s4 <= full_prod[FW-1:SW];
		sum_s4  <= sum_s3;
	end

	// estimate is low by at most one; the fix-up is applied after scaling
	assign rem   = sum_s4 - SW'(qest_s4) * SW'(tcc_pkg::LUMA_SCALE);
	assign a_est = AW'(qest_s4) * AW'(tcc_pkg::A_SCALE) + (AW'(1) << F);

	always_ff @(posedge clk) begin
		a_s5 <= a_est + ((rem >= SW'(tcc_pkg::LUMA_SCALE)) ? AW'(tcc_pkg::A_SCALE) : AW'(0));
	end

endmodule

// ===== sv/tcc_compare.sv =====
`timescale 1ns / 1ps

module tcc_compare #(
	parameter int unsigned LUM_FRAC_BITS = tcc_pkg::LUM_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s5,
	input  logic [LUM_FRAC_BITS+4:0]      a_bg,
	input  logic [LUM_FRAC_BITS+4:0]      a_tx,
	input  logic [31:0]                   text_color,
	input  logic [tcc_pkg::THR_W-1:0]     thr,
	output logic                          res_valid,
	output tcc_pkg::out_item_t            res
);

	localparam int unsigned F   = LUM_FRAC_BITS;
	localparam int unsigned AW  = F + 5;
	localparam int unsigned PW  = AW + tcc_pkg::THR_W;
	localparam int unsigned SQW = 2 * AW;
	localparam logic [SQW-1:0] BLACK_LIM = SQW'(tcc_pkg::CONTRAST_MAX) << (2 * F);

	logic           valid_s6;
	logic [PW-1:0]  p_bg_s6;
	logic [PW-1:0]  p_tx_s6;
	logic [SQW-1:0] sq_s6;
	logic           bg_gt_s6;
	logic [AW-1:0]  abg_s6;
	logic [AW-1:0]  atx_s6;
	logic [31:0]    tx_s6;
	logic           replace;
	logic           black;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		p_bg_s6  <= PW'(a_bg) * PW'(thr);
		p_tx_s6  <= PW'(a_tx) * PW'(thr);
		sq_s6    <= SQW'(a_bg) * SQW'(a_bg);
		bg_gt_s6 <= a_bg > a_tx;
		abg_s6   <= a_bg;
		atx_s6   <= a_tx;
		tx_s6    <= text_color;
	end

	// lighter side scaled by 256 against threshold times darker side
	always_comb begin
		if (bg_gt_s6) begin
			replace = (PW'(abg_s6) << tcc_pkg::THR_FRAC) < p_tx_s6;
		end else begin
			replace = (PW'(atx_s6) << tcc_pkg::THR_FRAC) < p_bg_s6;
		end
		black = sq_s6 > BLACK_LIM;
	end

	assign res_valid          = valid_s6;
	assign res.replaced       = replace;
	assign res.text_color_out = replace
		? (black ? tcc_pkg::BLACK_ARGB : tcc_pkg::WHITE_ARGB)
		: tx_s6;

endmodule

// ===== sv/tcc_out_queue.sv =====
`timescale 1ns / 1ps

module tcc_out_queue #(
	parameter int unsigned DEPTH = tcc_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_acc,
	output logic               in_stall,
	input  logic               wr_en,
	input  tcc_pkg::out_item_t wr_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tcc_pkg::out_item_t out_data
);

	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned PTW = $clog2(DEPTH);

	tcc_pkg::out_item_t mem_q [DEPTH];
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      occ_q;
	logic [PTW-1:0]     wr_ptr_q;
	logic [PTW-1:0]     rd_ptr_q;
	logic               out_acc;

	assign out_acc   = out_valid && !out_stall;
	assign out_valid = occ_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	// credits cover every item in the pipe, so the queue never overflows
	assign in_stall  = cnt_q == CW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			occ_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!in_acc && out_acc) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (wr_en && !out_acc) begin
				occ_q <= occ_q + CW'(1);
			end else if (!wr_en && out_acc) begin
				occ_q <= occ_q - CW'(1);
			end
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTW'(1);
			end
			if (out_acc) begin
				rd_ptr_q <= (rd_ptr_q == PTW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("credit count above queue depth");

	a_occ_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cnt_q)
		else $error("queue holds more items than were accepted");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (occ_q != CW'(DEPTH)))
		else $error("write into a full result queue");

	a_credit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !out_acc) |=> cnt_q == CW'($past(cnt_q) + CW'(1)))
		else $error("credit count did not follow an accepted item");

endmodule
